// ===== hw/rtl/lie_pkg.sv =====
// Package for the Lagrange interpolation evaluator.
// Request/result structs, command codes and the sequencer state type. No dependencies.
package lie_pkg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 24;

    typedef struct packed {
        logic               command;
        logic [2:0]         node_index;
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] interpolated_value;
        logic               divide_error;
        logic               saturated;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK_RD,
        ST_CHK_CMP,
        ST_RD_K,
        ST_RD_J,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV,
        ST_CLIP,
        ST_TERM,
        ST_ACC,
        ST_DONE
    } state_t;

endpackage

// ===== hw/rtl/lie_div.sv =====
// Radix-2 restoring divider, signed 64 by 33 bits, quotient truncated toward zero.
// Uses lie_pkg; one quotient bit per cycle.
module lie_div
    import lie_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic signed [63:0] dividend,
    input  logic signed [32:0] divisor,
    output logic               done,
    output logic signed [63:0] quotient
);

    logic [63:0] q_reg, q_next;
    logic [64:0] r_reg, r_next;
    logic [32:0] d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [64:0] shifted;
    logic [64:0] diff;

    // Shift-subtract datapath
    always_comb
    begin
        shifted   = {r_reg[63:0], q_reg[63]};
        diff      = shifted - {32'd0, d_reg};
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (go)
        begin
            q_next   = dividend[63] ? 64'(-dividend) : dividend;
            d_next   = divisor[32] ? 33'(-divisor) : divisor;
            neg_next = dividend[63] ^ divisor[32];
            r_next   = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!diff[64])
            begin
                r_next = diff;
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = shifted;
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? 64'(-q_reg) : q_reg;

endmodule

// ===== hw/rtl/lagrange_interpolation_evaluator.sv =====
// Lagrange interpolation evaluator: node table in two synchronous RAMs, two multipliers
// and a bit-serial divider (lie_div). A write is taken while idle and leaves busy low.
// An evaluate keeps busy high while it compares the abscissae and, if none are equal,
// runs the divider once per ordered node pair; the result strobe follows in the cycle
// after busy falls. The receiver cannot stall. Async active-low reset clears control
// and nodes_in_use (to 5); node RAM contents are undefined.
module lagrange_interpolation_evaluator
    import lie_pkg::*;
#(
    parameter int MAX_NODES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        request,
    output logic        result_valid,
    output res_t        result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    // Node memories
    logic signed [31:0] xmem [MAX_NODES];
    logic signed [31:0] ymem [MAX_NODES];
    logic [IW-1:0]      raddr;
    logic signed [31:0] xrd, yrd;

    state_t state_reg, state_next;
    logic [3:0]         niu_reg;
    logic [CW-1:0]      n_reg, n_next;
    logic [CW-1:0]      k_reg, k_next, j_reg, j_next;
    logic signed [31:0] q_reg, q_next;
    logic signed [31:0] xk_reg, xk_next, yk_reg, yk_next;
    logic signed [31:0] p_reg, p_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [32:0] den_reg, den_next;
    logic signed [63:0] sum_reg, sum_next;
    logic               sat_reg, sat_next;
    logic               div_go;
    logic               div_done;
    logic signed [63:0] div_q;
    logic               rv_reg, rv_next;
    res_t               res_reg, res_next;
    logic signed [63:0] term;
    logic signed [63:0] sum_c;

    logic accept;
    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // APB config register
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {28'd0, niu_reg} : 32'd0;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            niu_reg <= 4'd5;
        else if (psel && penable && pwrite && paddr == 2'd0)
            niu_reg <= pwdata[3:0];
    end

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (accept && request.command == CMD_WRITE
            && 5'(request.node_index) < 5'(MAX_NODES))
        begin
            xmem[IW'(request.node_index)] <= request.x_value;
            ymem[IW'(request.node_index)] <= request.y_value;
        end
        xrd <= xmem[raddr];
        yrd <= ymem[raddr];
    end

    lie_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (accept && request.command == CMD_EVAL) state_next = ST_CHK_RD;
            ST_CHK_RD:  state_next = ST_CHK_CMP;
            ST_CHK_CMP:
            begin
                if (xrd == xk_reg && j_reg != k_reg) state_next = ST_DONE;
                else if (j_reg == n_reg - 1'b1 && k_reg == n_reg - 1'b1)
                    state_next = ST_RD_K;
                else state_next = ST_CHK_RD;
            end
            ST_RD_K:    state_next = ST_RD_J;
            ST_RD_J:
            begin
                if (j_reg == n_reg) state_next = ST_TERM;
                else if (j_reg == k_reg) state_next = ST_RD_J;
                else state_next = ST_MUL;
            end
            ST_MUL:     state_next = ST_DIV_GO;
            ST_DIV_GO:  state_next = ST_DIV;
            ST_DIV:     if (div_done) state_next = ST_CLIP;
            ST_CLIP:    state_next = ST_RD_J;
            ST_TERM:    state_next = ST_ACC;
            ST_ACC:     state_next = (k_reg == n_reg - 1'b1) ? ST_DONE : ST_RD_K;
            ST_DONE:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        n_next    = n_reg;
        k_next    = k_reg;
        j_next    = j_reg;
        q_next    = q_reg;
        xk_next   = xk_reg;
        yk_next   = yk_reg;
        p_next    = p_reg;
        prod_next = prod_reg;
        den_next  = den_reg;
        sum_next  = sum_reg;
        sat_next  = sat_reg;
        rv_next   = 1'b0;
        res_next  = res_reg;
        div_go    = 1'b0;
        raddr     = IW'(k_reg);
        term      = 64'(64'(p_reg) * 64'(yk_reg));
        sum_c     = sum_reg;
        if (sum_reg > S32_MAX) sum_c = S32_MAX;
        else if (sum_reg < S32_MIN) sum_c = S32_MIN;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    q_next = request.x_value;
                    if (niu_reg == 4'd0) n_next = CW'(1);
                    else if (5'(niu_reg) > 5'(MAX_NODES)) n_next = CW'(MAX_NODES);
                    else n_next = CW'(niu_reg);
                    k_next   = '0;
                    j_next   = '0;
                    sum_next = '0;
                    sat_next = 1'b0;
                end
            end
            ST_CHK_RD:
            begin
                raddr = IW'(j_reg);
                // the j==k read loads the pivot; compare loop walks j for each k
            end
            ST_CHK_CMP:
            begin
                if (j_reg == k_reg) xk_next = xrd;
                if (j_reg == n_reg - 1'b1)
                begin
                    k_next = k_reg + 1'b1;
                    j_next = k_reg + 1'b1;
                    if (k_reg == n_reg - 1'b1)
                    begin
                        k_next = '0;
                        j_next = '0;
                    end
                end
                else j_next = j_reg + 1'b1;
                if (xrd == xk_reg && j_reg != k_reg)
                begin
                    res_next = '{interpolated_value: '0, divide_error: 1'b1, saturated: 1'b0};
                end
            end
            ST_RD_K:
            begin
                raddr  = IW'(k_reg);
                j_next = '0;
                p_next = 32'sd16777216;
            end
            ST_RD_J:
            begin
                raddr = IW'(j_reg);
                if (j_reg == '0)
                begin
                    xk_next = xrd;
                    yk_next = yrd;
                end
                if (j_reg == k_reg) j_next = j_reg + 1'b1;
            end
            ST_MUL:
            begin
                prod_next = 64'(64'(p_reg) * (64'(q_reg) - 64'(xrd)));
                den_next  = 33'(xk_reg) - 33'(xrd);
            end
            ST_DIV_GO:
            begin
                // operands are registered now
                div_go = 1'b1;
            end
            ST_DIV: ;
            ST_CLIP:
            begin
                if (div_q > S32_MAX) begin p_next = 32'h7fffffff; sat_next = 1'b1; end
                else if (div_q < S32_MIN) begin p_next = 32'h80000000; sat_next = 1'b1; end
                else p_next = div_q[31:0];
                j_next = j_reg + 1'b1;
            end
            ST_TERM:
            begin
                prod_next = term;
            end
            ST_ACC:
            begin
                sum_next = sum_reg + (prod_reg[63] ?
                    -((-prod_reg) >>> FRAC_W) : (prod_reg >>> FRAC_W));
                k_next = k_reg + 1'b1;
            end
            ST_DONE:
            begin
                rv_next = 1'b1;
                if (!res_reg.divide_error)
                begin
                    res_next.interpolated_value = sum_c[31:0];
                    res_next.saturated = sat_reg || (sum_c != sum_reg);
                end
            end
            default: ;
        endcase
        if (state_reg == ST_IDLE && accept) res_next = '0;
    end

    // Note: ST_RD_J loads xk/yk when j is 0 from the k read issued in ST_RD_K;
    // the j read for j==0 then arrives in ST_MUL, or goes unused when the j==k skip is taken.

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        k_reg    <= k_next;
        j_reg    <= j_next;
        q_reg    <= q_next;
        xk_reg   <= xk_next;
        yk_reg   <= yk_next;
        p_reg    <= p_next;
        prod_reg <= prod_next;
        den_reg  <= den_next;
        sum_reg  <= sum_next;
        sat_reg  <= sat_next;
        res_reg  <= res_next;
    end

    assign result_valid = rv_reg;
    assign result       = res_reg;

endmodule

// ===== hw/rtl/lie_checker.sv =====
// Port-level checker for the Lagrange interpolation evaluator, with its bind.
// Uses lie_pkg.
module lie_checker
    import lie_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic result_valid,
    input res_t result,
    input logic pready
);

    // A result strobe lasts one cycle
    a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid) else $error("result strobe held");

    // A result only follows a busy period
    a_res_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy)) else $error("result without busy");

    // Busy only rises after a request was presented
    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start)) else $error("busy without request");

    // Divide error reports zero value and no saturation
    a_div_err: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.divide_error) |-> (result.interpolated_value == 0
        && !result.saturated)) else $error("bad divide error result");

    // Port is always ready
    a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind lagrange_interpolation_evaluator lie_checker u_lie_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result),
    .pready       (pready)
);

// ===== verif/lagrange_interpolation_evaluator_tb.sv =====
// Testbench for lagrange_interpolation_evaluator: a directed table, then random requests
// over several node counts, checked against an in-bench fixed-point predictor.
// Depends on lie_pkg and the evaluator RTL only.
`timescale 1ns / 1ps

module lagrange_interpolation_evaluator_tb;
    import lie_pkg::*;

    localparam int TABLE_SIZE = 8;
    localparam logic [1:0] ADDR_NODES_IN_USE = 2'd0;
    localparam logic signed [95:0] Q_ONE = 96'sd16777216;
    localparam logic signed [95:0] S32_MAX = 96'sd2147483647;
    localparam logic signed [95:0] S32_MIN = -96'sd2147483648;

    typedef struct {
        req_t req;
        bit   typed;
        res_t exp;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        request;
    logic        result_valid;
    res_t        result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    logic signed [31:0] node_x[TABLE_SIZE];
    logic signed [31:0] node_y[TABLE_SIZE];
    logic [3:0]         nodes_cfg;

    res_t expected_q[$];
    row_t directed[$];
    int   err_count;
    int   write_count;
    int   eval_count;
    int   result_count;
    int   sat_count;
    int   div_err_count;
    int   idle_pct;

    lagrange_interpolation_evaluator DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .result_valid(result_valid), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    task automatic report_mismatch(input string what, input longint got, input longint exp);
        err_count++;
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $time);
    endtask

    // Lagrange value at query point, weights built left to right
    function automatic res_t lagrange_eval(input logic signed [31:0] xq);
        res_t r;
        int n;
        logic signed [95:0] p;
        logic signed [95:0] num;
        logic signed [95:0] den;
        logic signed [95:0] sum;
        bit sat;
        n = nodes_cfg;
        if (n < 1) n = 1;
        if (n > TABLE_SIZE) n = TABLE_SIZE;
        r = '0;
        sat = 0;
        sum = 0;
        for (int k = 0; k < n; k++)
            for (int j = k + 1; j < n; j++)
                if (node_x[k] == node_x[j])
                    r.divide_error = 1'b1;
        if (r.divide_error)
            return r;
        for (int k = 0; k < n; k++)
        begin
            p = Q_ONE;
            for (int j = 0; j < n; j++)
            begin
                if (j == k) continue;
                num = 96'(xq) - 96'(node_x[j]);
                den = 96'(node_x[k]) - 96'(node_x[j]);
                p = (p * num) / den;
                if (p > S32_MAX)
                begin
                    p = S32_MAX;
                    sat = 1;
                end
                else if (p < S32_MIN)
                begin
                    p = S32_MIN;
                    sat = 1;
                end
            end
            sum = sum + (p * 96'(node_y[k])) / Q_ONE;
        end
        if (sum > S32_MAX)
        begin
            sum = S32_MAX;
            sat = 1;
        end
        else if (sum < S32_MIN)
        begin
            sum = S32_MIN;
            sat = 1;
        end
        r.interpolated_value = sum[31:0];
        r.saturated = sat;
        return r;
    endfunction

    // issue one request and update the predictor once it is taken;
    // start stays high on return so back-to-back requests need no gap
    task automatic send_request(input req_t r, input bit typed, input res_t exp);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        start <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        if (r.command == CMD_WRITE)
        begin
            node_x[r.node_index] = r.x_value;
            node_y[r.node_index] = r.y_value;
            write_count++;
        end
        else
        begin
            expected_q.push_back(typed ? exp : lagrange_eval(r.x_value));
            eval_count++;
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (expected_q.size() != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_nodes_in_use(input logic [3:0] value);
        logic [31:0] readback;
        wait_idle();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_NODES_IN_USE;
        pwdata <= {28'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        nodes_cfg = value;
        if (readback[3:0] != value)
            report_mismatch("nodes_in_use readback", readback[3:0], value);
    endtask

    function automatic logic signed [31:0] rand_coord();
        logic signed [31:0] v;
        case ($urandom_range(9))
            0, 1: v = $urandom();
            2: v = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default:
            begin
                v = $signed($urandom_range(16)) - 8;
                v = (v <<< 24) | ($urandom() & 32'h00ff_ffff);
            end
        endcase
        return v;
    endfunction

    task automatic add_row(input logic cmd, input int idx, input logic signed [31:0] xv,
                           input logic signed [31:0] yv, input bit typed, input res_t exp);
        row_t row;
        row.req = '{command: cmd, node_index: 3'(idx), x_value: xv, y_value: yv};
        row.typed = typed;
        row.exp = exp;
        directed.push_back(row);
    endtask

    // result checker; the receiver never stalls
    always @(posedge clk)
    begin
        res_t exp;
        if (rst_n && result_valid)
        begin
            result_count++;
            if (result.saturated) sat_count++;
            if (result.divide_error) div_err_count++;
            if (expected_q.size() == 0)
                report_mismatch("unexpected result", result, 0);
            else
            begin
                exp = expected_q.pop_front();
                if (result.interpolated_value !== exp.interpolated_value)
                    report_mismatch("interpolated_value", result.interpolated_value,
                                    exp.interpolated_value);
                if (result.divide_error !== exp.divide_error)
                    report_mismatch("divide_error", result.divide_error, exp.divide_error);
                if (result.saturated !== exp.saturated)
                    report_mismatch("saturated", result.saturated, exp.saturated);
            end
        end
    end

    initial
    begin
        #250_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        res_t none;
        res_t divz;
        req_t r;
        int counts[$];
        logic [3:0] settings[$];
        none = '0;
        divz = '0;
        divz.divide_error = 1'b1;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_pct = 0;
        nodes_cfg = 4'd5;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            node_x[i] = 0;
            node_y[i] = 0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: fill every slot, hit nodes exactly, extremes, equal abscissae
        for (int i = 0; i < TABLE_SIZE; i++)
            add_row(CMD_WRITE, i, i <<< 24, (i * 3 - 5) <<< 24, 0, none);
        none.interpolated_value = 1 <<< 24;
        add_row(CMD_EVAL, 0, 2 <<< 24, 0, 1, none);
        none.interpolated_value = -5 <<< 24;
        add_row(CMD_EVAL, 0, 0, 0, 1, none);
        add_row(CMD_EVAL, 0, 32'sh7fffffff, 0, 0, none);
        add_row(CMD_EVAL, 0, 32'sh80000000, 0, 0, none);
        add_row(CMD_WRITE, 3, 1 <<< 24, 32'sh7fffffff, 0, none);
        add_row(CMD_EVAL, 0, 5 <<< 24, 0, 1, divz);
        add_row(CMD_WRITE, 3, 3 <<< 24, -8 <<< 24, 0, none);
        none.interpolated_value = -8 <<< 24;
        add_row(CMD_EVAL, 0, 3 <<< 24, 0, 1, none);
        add_row(CMD_WRITE, 4, 32'sh7fffffff, 32'sh80000000, 0, none);
        add_row(CMD_EVAL, 0, 32'sh00800000, 0, 0, none);
        add_row(CMD_WRITE, 4, 4 <<< 24, 32'sh7fffffff, 0, none);
        add_row(CMD_EVAL, 0, 32'shff000000, 0, 0, none);
        foreach (directed[i])
            send_request(directed[i].req, directed[i].typed, directed[i].exp);

        // random phases over node counts, extremes and out-of-range values included
        settings = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd3, 4'd4, 4'd3, 4'd2, 4'd6, 4'd1, 4'd4};
        counts   = '{80, 20, 70, 10, 90, 90, 80, 90, 90, 30, 60, 70};
        foreach (settings[ph])
        begin
            set_nodes_in_use(settings[ph]);
            // sender gaps rotate: none, heavy, none, light
            idle_pct = (ph % 4 == 1) ? 87 : ((ph % 4 == 3) ? 16 : 0);
            for (int i = 0; i < counts[ph]; i++)
            begin
                r.command = ($urandom_range(1) == 0) ? CMD_WRITE : CMD_EVAL;
                r.node_index = $urandom_range(7);
                r.x_value = rand_coord();
                r.y_value = rand_coord();
                send_request(r, 0, none);
            end
        end
        set_nodes_in_use(4'd5);

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("covered %0d node writes and %0d evaluations over node counts 0..15",
                 write_count, eval_count);
        $display("results %0d, saturated %0d, divide errors %0d",
                 result_count, sat_count, div_err_count);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/lie_pkg.sv
hw/rtl/lie_div.sv
hw/rtl/lagrange_interpolation_evaluator.sv
hw/rtl/lie_checker.sv
verif/lagrange_interpolation_evaluator_tb.sv
